// ----- rtl/front_coded_word_list_decoder_core_assert.svh -----
// Assertion helpers used by the decoder core.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef FRONT_CODED_WORD_LIST_DECODER_CORE_ASSERT_SVH
`define FRONT_CODED_WORD_LIST_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCWLD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("front coded word list decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCWLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("front coded word list decoder check failed");

`endif

// ----- rtl/fcwld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fcwld_pkg;

    localparam int MAX_WORD_LEN_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 6;
    localparam int LETTER_W = 7;
    localparam int SYN_W    = 16;
    localparam int ALU_W    = 16;

    localparam logic [SYN_W-1:0]    IGNORED_SYN_RESET = 16'd9999;
    localparam logic [LETTER_W-1:0] CHAR_XOR          = 7'h7F;

    localparam logic ITEM_CHAR = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // Operands presented to the shared compare and increment unit.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Results: a < b, and a + 1.
    typedef struct packed {
        logic             lt;
        logic [ALU_W-1:0] inc;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/fcwld_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input byte stream channel.
interface fcwld_byte_if;
    logic                           valid;
    logic                           ready;
    logic [fcwld_pkg::BYTE_W-1:0]   stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// Decoded result channel.
interface fcwld_result_if;
    logic                           valid;
    logic                           ready;
    logic                           item_kind;
    logic [fcwld_pkg::POS_W-1:0]    char_position;
    logic [fcwld_pkg::LETTER_W-1:0] letter;
    logic [fcwld_pkg::SYN_W-1:0]    synonym_number;
    logic [fcwld_pkg::SYN_W-1:0]    word_index;
    logic [fcwld_pkg::SYN_W-1:0]    max_synonym;
    logic                           overflow;
    logic                           last_of_word;

    modport source (output valid, output item_kind, output char_position, output letter,
                    output synonym_number, output word_index, output max_synonym,
                    output overflow, output last_of_word, input ready);
    modport sink   (input valid, input item_kind, input char_position, input letter,
                    input synonym_number, input word_index, input max_synonym,
                    input overflow, input last_of_word, output ready);
endinterface

// Configuration write channel for the ignored synonym register.
interface fcwld_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fcwld_pkg::SYN_W-1:0]    ignored_synonym;

    modport source (output valid, output ignored_synonym, input ready);
    modport sink   (input valid, input ignored_synonym, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcwld_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared compare and increment unit; the sequencer picks the operands each cycle.
module fcwld_alu
(
    input  wire fcwld_pkg::alu_req_t req,
    output fcwld_pkg::alu_rsp_t      rsp
);

    always_comb
    begin
        rsp.lt  = (req.a < req.b);
        rsp.inc = req.a + {{(fcwld_pkg::ALU_W-1){1'b0}}, 1'b1};
    end

endmodule

`default_nettype wire

// ----- rtl/fcwld_word_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Word buffer: one write port and one registered read port.
module fcwld_word_buf
#(
    parameter int DEPTH  = fcwld_pkg::MAX_WORD_LEN_DEF,
    parameter int ADDR_W = $clog2(fcwld_pkg::MAX_WORD_LEN_DEF)
)
(
    input  wire                                 clk,
    input  wire                                 wr_en,
    input  wire  [ADDR_W-1:0]                   wr_addr,
    input  wire  [fcwld_pkg::LETTER_W-1:0]      wr_data,
    input  wire                                 rd_en,
    input  wire  [ADDR_W-1:0]                   rd_addr,
    output logic [fcwld_pkg::LETTER_W-1:0]      rd_data
);

    logic [fcwld_pkg::LETTER_W-1:0] mem [DEPTH];
    logic [fcwld_pkg::LETTER_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/front_coded_word_list_decoder_core.sv -----
// Prefix, character and synonym high bytes are taken whenever valid; no results follow them.
// The synonym low byte starts a burst: the maximum update, then for each character a buffer
// read and an output load, then the final length check and the end transaction. The stream
// is not ready during the burst; output stalls stretch each load. Reset (rst_n low,
// asynchronous) clears the sequencer, counters, flags and output valid, and loads 9999 into
// the ignored synonym register; the word buffer holds no reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "front_coded_word_list_decoder_core_assert.svh"

module front_coded_word_list_decoder_core
#(
    parameter int MAX_WORD_LEN = fcwld_pkg::MAX_WORD_LEN_DEF
)
(
    input  wire              clk,
    input  wire              rst_n,
    fcwld_byte_if.sink       stream,
    fcwld_result_if.source   result,
    fcwld_cfg_if.sink        cfg
);

    localparam int ADDR_W = $clog2(MAX_WORD_LEN);
    localparam int POS_W  = fcwld_pkg::POS_W;
    localparam int SYN_W  = fcwld_pkg::SYN_W;
    localparam int ALU_W  = fcwld_pkg::ALU_W;
    localparam int LET_W  = fcwld_pkg::LETTER_W;
    localparam int BYTE_W = fcwld_pkg::BYTE_W;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORD_LEN);
    localparam logic [ALU_W-1:0] MAX_ALU = ALU_W'(MAX_WORD_LEN);

    // Sequencer states. The first four take stream bytes; the rest run the output burst.
    localparam logic [2:0] ST_PREFIX = 3'd0;
    localparam logic [2:0] ST_CHARS  = 3'd1;
    localparam logic [2:0] ST_SYN_HI = 3'd2;
    localparam logic [2:0] ST_SYN_LO = 3'd3;
    localparam logic [2:0] ST_MAX    = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_WR     = 3'd6;
    localparam logic [2:0] ST_END    = 3'd7;

    logic [2:0]        state_reg,   state_next;
    logic [POS_W-1:0]  wp_reg,      wp_next;
    logic [POS_W-1:0]  idx_reg,     idx_next;
    logic [BYTE_W-1:0] syn_hi_reg,  syn_hi_next;
    logic [SYN_W-1:0]  syn_reg,     syn_next;
    logic [SYN_W-1:0]  count_reg,   count_next;
    logic [SYN_W-1:0]  largest_reg, largest_next;
    logic              ovf_reg,     ovf_next;
    logic [SYN_W-1:0]  ignored_reg, ignored_next;

    // Output register; it holds a finished transaction while the next stream bytes arrive.
    logic              out_valid_reg,   out_valid_next;
    logic              out_kind_reg,    out_kind_next;
    logic [POS_W-1:0]  out_pos_reg,     out_pos_next;
    logic [LET_W-1:0]  out_letter_reg,  out_letter_next;
    logic [SYN_W-1:0]  out_syn_reg,     out_syn_next;
    logic [SYN_W-1:0]  out_index_reg,   out_index_next;
    logic [SYN_W-1:0]  out_max_reg,     out_max_next;
    logic              out_ovf_reg,     out_ovf_next;
    logic              out_last_reg,    out_last_next;

    fcwld_pkg::alu_req_t alu_req;
    fcwld_pkg::alu_rsp_t alu_rsp;

    logic              in_fire;
    logic              slot_free;
    logic              load_char;
    logic              load_end;
    logic              buf_wr_en;
    logic              buf_rd_en;
    logic [LET_W-1:0]  buf_rd_data;
    logic [LET_W-1:0]  letter_in;

    assign stream.ready = (state_reg == ST_PREFIX) || (state_reg == ST_CHARS) ||
                          (state_reg == ST_SYN_HI) || (state_reg == ST_SYN_LO);
    assign in_fire   = stream.valid && stream.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign letter_in = stream.stream_byte[LET_W-1:0] ^ fcwld_pkg::CHAR_XOR;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_req.a = '0;
        alu_req.b = '0;
        unique case (state_reg)
            ST_PREFIX:
            begin
                // Prefix too long when MAX_WORD_LEN < prefix.
                alu_req.a = MAX_ALU;
                alu_req.b = ALU_W'(stream.stream_byte);
            end
            ST_CHARS:
            begin
                alu_req.a = ALU_W'(wp_reg);
                alu_req.b = MAX_ALU;
            end
            ST_MAX:
            begin
                alu_req.a = largest_reg;
                alu_req.b = syn_reg;
            end
            ST_RD, ST_WR:
            begin
                alu_req.a = ALU_W'(idx_reg);
                alu_req.b = ALU_W'(wp_reg);
            end
            ST_END:
            begin
                alu_req.a = count_reg;
            end
            ST_SYN_HI, ST_SYN_LO:
            begin
                alu_req.a = '0;
            end
        endcase
    end

    fcwld_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign buf_wr_en = (state_reg == ST_CHARS) && in_fire && alu_rsp.lt;
    assign buf_rd_en = (state_reg == ST_RD) && alu_rsp.lt;
    assign load_char = (state_reg == ST_WR) && slot_free;
    assign load_end  = (state_reg == ST_END) && slot_free;

    fcwld_word_buf
    #(
        .DEPTH  (MAX_WORD_LEN),
        .ADDR_W (ADDR_W)
    )
    u_word_buf
    (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (wp_reg[ADDR_W-1:0]),
        .wr_data (letter_in),
        .rd_en   (buf_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (buf_rd_data)
    );

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        idx_next     = idx_reg;
        syn_hi_next  = syn_hi_reg;
        syn_next     = syn_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        ovf_next     = ovf_reg;
        ignored_next = ignored_reg;

        if (cfg.valid)
        begin
            ignored_next = cfg.ignored_synonym;
        end

        unique case (state_reg)
            ST_PREFIX:
            begin
                if (in_fire)
                begin
                    if (alu_rsp.lt)
                    begin
                        ovf_next = 1'b1;
                        wp_next  = MAX_POS;
                    end
                    else
                    begin
                        // The prefix is at most MAX_WORD_LEN here, so it fits the position.
                        wp_next = stream.stream_byte[POS_W-1:0];
                    end
                    state_next = ST_CHARS;
                end
            end
            ST_CHARS:
            begin
                if (in_fire)
                begin
                    if (alu_rsp.lt)
                    begin
                        wp_next = alu_rsp.inc[POS_W-1:0];
                    end
                    else
                    begin
                        // Buffer full: the character is dropped.
                        ovf_next = 1'b1;
                    end
                    if (stream.stream_byte[BYTE_W-1])
                    begin
                        state_next = ST_SYN_HI;
                    end
                end
            end
            ST_SYN_HI:
            begin
                if (in_fire)
                begin
                    syn_hi_next = stream.stream_byte;
                    state_next  = ST_SYN_LO;
                end
            end
            ST_SYN_LO:
            begin
                if (in_fire)
                begin
                    syn_next   = {syn_hi_reg, stream.stream_byte};
                    state_next = ST_MAX;
                end
            end
            ST_MAX:
            begin
                if (alu_rsp.lt && (syn_reg != ignored_reg))
                begin
                    largest_next = syn_reg;
                end
                idx_next   = '0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = alu_rsp.lt ? ST_WR : ST_END;
            end
            ST_WR:
            begin
                if (slot_free)
                begin
                    idx_next   = alu_rsp.inc[POS_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    count_next = alu_rsp.inc;
                    ovf_next   = 1'b0;
                    state_next = ST_PREFIX;
                end
            end
        endcase
    end

    // Output register loading. The word index and overflow flag are captured before the
    // end transaction advances the counter and clears the flag.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_pos_next    = out_pos_reg;
        out_letter_next = out_letter_reg;
        out_syn_next    = out_syn_reg;
        out_index_next  = out_index_reg;
        out_max_next    = out_max_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        if (load_char || load_end)
        begin
            out_valid_next = 1'b1;
            out_index_next = count_reg;
            out_max_next   = largest_reg;
            out_ovf_next   = ovf_reg;
        end

        if (load_char)
        begin
            out_kind_next   = fcwld_pkg::ITEM_CHAR;
            out_pos_next    = idx_reg;
            out_letter_next = buf_rd_data;
            out_syn_next    = '0;
            out_last_next   = 1'b0;
        end
        else if (load_end)
        begin
            out_kind_next   = fcwld_pkg::ITEM_END;
            out_pos_next    = wp_reg;
            out_letter_next = '0;
            out_syn_next    = syn_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PREFIX;
            wp_reg        <= '0;
            idx_reg       <= '0;
            syn_hi_reg    <= '0;
            syn_reg       <= '0;
            count_reg     <= '0;
            largest_reg   <= '0;
            ovf_reg       <= 1'b0;
            ignored_reg   <= fcwld_pkg::IGNORED_SYN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            idx_reg       <= idx_next;
            syn_hi_reg    <= syn_hi_next;
            syn_reg       <= syn_next;
            count_reg     <= count_next;
            largest_reg   <= largest_next;
            ovf_reg       <= ovf_next;
            ignored_reg   <= ignored_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_pos_reg    <= out_pos_next;
        out_letter_reg <= out_letter_next;
        out_syn_reg    <= out_syn_next;
        out_index_reg  <= out_index_next;
        out_max_reg    <= out_max_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.item_kind      = out_kind_reg;
    assign result.char_position  = out_pos_reg;
    assign result.letter         = out_letter_reg;
    assign result.synonym_number = out_syn_reg;
    assign result.word_index     = out_index_reg;
    assign result.max_synonym    = out_max_reg;
    assign result.overflow       = out_ovf_reg;
    assign result.last_of_word   = out_last_reg;

    // The write position never passes the buffer size.
    `FCWLD_ASSERT_SAME(a_wp_bound, 1'b1, wp_reg <= MAX_POS)
    // A character transaction is only loaded for a position inside the word.
    `FCWLD_ASSERT_SAME(a_char_in_word, load_char, idx_reg < wp_reg)
    // The end transaction closes the burst and the next prefix byte is expected.
    `FCWLD_ASSERT_NEXT(a_end_to_prefix, load_end, (state_reg == ST_PREFIX) && !ovf_reg)
    // An end-marked character byte moves on to the synonym bytes.
    `FCWLD_ASSERT_NEXT(a_end_mark, in_fire && (state_reg == ST_CHARS) &&
                       stream.stream_byte[BYTE_W-1], state_reg == ST_SYN_HI)

endmodule

`default_nettype wire
